// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/slis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slis_pkg;

  // Store size and width of one stored entry.
  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;

  // Derived widths: cell index and entry count.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths of the ports.
  localparam int FIELD_VAL_W = 32;
  localparam int FIELD_POS_W = 5;
  localparam int FIELD_CNT_W = 6;

  // Saturation limits of a stored entry, held wide enough for any width up to 64 bits.
  localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (VALUE_BITS - 1)) - 65'sd1;
  localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;

  // Command codes.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // One input beat.
  typedef struct packed {
    logic [1:0]                     cmd;
    logic signed [FIELD_VAL_W-1:0]  value_in;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic signed [FIELD_VAL_W-1:0]  value_out;
    logic [FIELD_POS_W-1:0]         position;
    logic [FIELD_CNT_W-1:0]         count;
    logic                           overflow;
    logic                           empty_res;
    logic                           last;
  } out_t;

  // Control of one cell in the chain.
  typedef struct packed {
    logic ins;     // sorted insert this cycle
    logic app;     // append this cycle
    logic rot;     // rotate the ring one place toward cell zero
    logic valid;   // cell holds an entry
    logic at_end;  // cell is the first free one
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/slis_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slis_cell import slis_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  value_t     new_val,
  input  value_t     left_val,
  input  logic       left_gt,
  input  value_t     right_val,
  output value_t     val,
  output logic       gt
);

  // This entry, or one held before it, is larger than the incoming value.
  // The flag is carried along the chain, so every entry from the insert
  // place upward moves, even when appends have left the store out of order.
  always_comb begin
    gt = ctrl.valid && (left_gt || (val > new_val));
  end

  // On insert a larger entry moves up one place; the first larger or free cell takes the new value.
  always_ff @(posedge clk) begin
    if (ctrl.rot) begin
      val <= right_val;
    end else if (ctrl.ins && (gt || ctrl.at_end)) begin
      val <= left_gt ? left_val : new_val;
    end else if (ctrl.app && ctrl.at_end) begin
      val <= new_val;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_list_insert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake             Payload   Notes
// input     start / busy          item      beat taken when start && !busy
// result    strobe                result    one cycle per beat, no back-pressure
//
// Append and insert are taken while idle; the result is strobed in the next
// cycle and a new command may be taken in that same cycle.
// A dump holds busy while the cell chain rotates once
// around its ring; entries stream out one per cycle from cell zero.
// An empty dump and a full store give one result without raising busy.
// Reset clears the entry count and the state; no clearing pass is run.

module sorted_list_insert import slis_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic strobe,
  output out_t result
);

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] dump_idx;

  logic             accept;
  logic             full;
  logic             do_ins;
  logic             do_app;
  logic signed [64:0] wide_in;
  value_t           sat_val;
  logic [IDX_W-1:0] ins_pos;

  cell_ctrl_t       ctrl  [CAPACITY];
  value_t           cval  [CAPACITY];
  logic             cgt   [CAPACITY];
  logic             place [CAPACITY];

  assign busy   = (state == ST_DUMP);
  assign accept = start && !busy;
  assign full   = (count >= CNT_W'(CAPACITY));
  assign do_ins = accept && (item.cmd == CMD_INSERT) && !full;
  assign do_app = accept && (item.cmd == CMD_APPEND) && !full;

  // Saturate the incoming value to the stored width.
  always_comb begin
    wide_in = 65'(item.value_in);
    if (wide_in > SAT_HI) begin
      sat_val = VALUE_BITS'(SAT_HI);
    end else if (wide_in < SAT_LO) begin
      sat_val = VALUE_BITS'(SAT_LO);
    end else begin
      sat_val = VALUE_BITS'(wide_in);
    end
  end

  // Per-cell control: occupancy and the first free place.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].ins    = do_ins;
      ctrl[i].app    = do_app;
      ctrl[i].rot    = (state == ST_DUMP);
      ctrl[i].valid  = (CNT_W'(i) < count);
      ctrl[i].at_end = (CNT_W'(i) == count);
    end
  end

  // The chain of cells, closed into a ring for the dump rotation.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slis_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .new_val   (sat_val),
      .left_val  ((g == 0) ? cval[0] : cval[(g + CAPACITY - 1) % CAPACITY]),
      .left_gt   ((g == 0) ? 1'b0 : cgt[(g + CAPACITY - 1) % CAPACITY]),
      .right_val (cval[(g + 1) % CAPACITY]),
      .val       (cval[g]),
      .gt        (cgt[g])
    );
  end

  // Insert position: the first cell that is larger or free.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      place[i] = cgt[i] || ctrl[i].at_end;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (place[i] && ((i == 0) || !place[(i + CAPACITY - 1) % CAPACITY])) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  // State, count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      strobe   <= 1'b0;
      dump_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // Stores and an empty dump answer at once; a non-empty dump starts the ring.
          strobe <= accept && ((item.cmd == CMD_APPEND) || (item.cmd == CMD_INSERT) ||
                               ((item.cmd == CMD_DUMP) && (count == '0)));
          if (accept) begin
            if (item.cmd == CMD_DUMP) begin
              if (count == '0) begin
                result.value_out <= '0;
                result.position  <= '0;
                result.count     <= '0;
                result.overflow  <= 1'b0;
                result.empty_res <= 1'b1;
                result.last      <= 1'b1;
              end else begin
                state    <= ST_DUMP;
                dump_idx <= '0;
              end
            end else if ((item.cmd == CMD_APPEND) || (item.cmd == CMD_INSERT)) begin
              result.value_out <= FIELD_VAL_W'(sat_val);
              result.empty_res <= 1'b0;
              result.last      <= 1'b1;
              if (full) begin
                result.position <= '0;
                result.count    <= FIELD_CNT_W'(count);
                result.overflow <= 1'b1;
              end else begin
                count           <= count + CNT_W'(1);
                result.count    <= FIELD_CNT_W'(count + CNT_W'(1));
                result.overflow <= 1'b0;
                if (item.cmd == CMD_APPEND) begin
                  result.position <= FIELD_POS_W'(count);
                end else begin
                  result.position <= FIELD_POS_W'(ins_pos);
                end
              end
            end
          end
        end
        ST_DUMP: begin
          // Cell zero holds the entry at dump_idx while the ring turns.
          strobe           <= (CNT_W'(dump_idx) < count);
          result.value_out <= FIELD_VAL_W'(cval[0]);
          result.position  <= FIELD_POS_W'(dump_idx);
          result.count     <= FIELD_CNT_W'(count);
          result.overflow  <= 1'b0;
          result.empty_res <= 1'b0;
          result.last      <= ((CNT_W'(dump_idx) + CNT_W'(1)) == count);
          dump_idx         <= dump_idx + IDX_W'(1);
          if (dump_idx == IDX_W'(CAPACITY - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slis_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slis_checker import slis_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input in_t  item,
  input logic strobe,
  input out_t result
);

  // An empty dump is a single closing beat with a zero count.
  `ASSERT_CLK(a_empty_beat, clk, rst, strobe && result.empty_res |-> result.last && (result.count == '0) && !result.overflow, "empty dump beat malformed")

  // A dropped value is only reported with a full store.
  `ASSERT_CLK(a_overflow_full, clk, rst, strobe && result.overflow |-> (result.count == FIELD_CNT_W'(CAPACITY)) && result.last, "overflow without full store")

  // Append and insert answer with one closing beat in the next cycle.
  `ASSERT_CLK(a_store_answer, clk, rst, start && !busy && ((item.cmd == CMD_APPEND) || (item.cmd == CMD_INSERT)) |=> strobe && result.last, "missing store result")

  // Results follow only an accepted command or an ongoing dump.
  `ASSERT_CLK(a_no_stray, clk, rst, strobe |-> $past(start && !busy) || $past(busy), "result beat without cause")

  // Leaving reset leaves the block ready for a command.
  `ASSERT_CLK_NR(a_reset_idle, clk, $past(rst) |-> !busy && !strobe, "not idle after reset")

endmodule

bind sorted_list_insert slis_checker u_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import slis_pkg::*;

  // The package names no code for the unused command.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    in_t beat;
    int  idle_pct;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic busy;
  logic strobe;
  out_t result;

  pending_t pending_items[$];
  out_t     expected_results[$];
  int       mismatches = 0;
  int       cycle_count = 0;

  // Shadow copy of the ordered store.
  value_t shadow_values[CAPACITY];
  int     shadow_count = 0;

  sorted_list_insert uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result beats that one accepted command beat causes and
  // updates the shadow store.
  task automatic predict_results(input in_t beat);
    logic signed [64:0] wide;
    value_t v;
    out_t r;
    int pos;
    wide = beat.value_in;
    if (wide > SAT_HI) wide = SAT_HI;
    else if (wide < SAT_LO) wide = SAT_LO;
    v = wide[VALUE_BITS-1:0];
    r = '0;
    case (beat.cmd)
      CMD_DUMP: begin
        if (shadow_count == 0) begin
          r.empty_res = 1'b1;
          r.last = 1'b1;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            r.value_out = shadow_values[i];
            r.position = FIELD_POS_W'(i);
            r.count = FIELD_CNT_W'(shadow_count);
            r.last = (i == shadow_count - 1);
            expected_results.push_back(r);
          end
        end
      end
      CMD_APPEND, CMD_INSERT: begin
        r.value_out = v;
        r.last = 1'b1;
        if (shadow_count >= CAPACITY) begin
          // Full store: the value is dropped and flagged.
          r.count = FIELD_CNT_W'(shadow_count);
          r.overflow = 1'b1;
        end else begin
          pos = shadow_count;
          if (beat.cmd == CMD_INSERT) begin
            // Goes before the first entry greater than it.
            pos = 0;
            while (pos < shadow_count && shadow_values[pos] <= v) pos++;
            for (int i = shadow_count; i > pos; i--) shadow_values[i] = shadow_values[i-1];
          end
          shadow_values[pos] = v;
          shadow_count++;
          r.position = FIELD_POS_W'(pos);
          r.count = FIELD_CNT_W'(shadow_count);
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Random values lean toward small ranges so that equal entries are common.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: begin
        v = $urandom_range(15);
        v = (v - 32'sd8) <<< 16;
      end
      2: begin
        v = $urandom_range(63);
        v = v - 32'sd32;
      end
      default: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Driver: offers the next pending beat unless this cycle is left idle.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= pending_items[0].idle_pct) begin
        item <= pending_items[0].beat;
        start <= 1'b1;
        void'(pending_items.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation, then
  // records the expectations of a command beat taken at this edge.
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst) begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result beat: %p", result);
        end else begin
          exp_r = expected_results.pop_front();
          if (result.value_out !== exp_r.value_out || result.position !== exp_r.position ||
              result.count !== exp_r.count || result.overflow !== exp_r.overflow ||
              result.empty_res !== exp_r.empty_res || result.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected %p, got %p", exp_r, result);
          end
        end
      end
      if (start && !busy) predict_results(item);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sorted_list_insert");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] cmd, input logic signed [31:0] value,
                          input int idle_pct);
    pending_t p;
    p.beat.cmd = cmd;
    p.beat.value_in = value;
    p.idle_pct = idle_pct;
    pending_items.push_back(p);
  endtask

  initial begin
    int stored_items;
    int idle_pct;
    int pick;
    stored_items = 0;

    // Directed part: empty dump, unused command, extremes, equal values,
    // an append that breaks the order, and dumps of the result.
    add_item(CMD_DUMP, 32'sh0, 0);
    add_item(CMD_UNUSED, $urandom, 0);
    add_item(CMD_APPEND, 32'sh7FFF_FFFF, 0);
    add_item(CMD_INSERT, 32'sh8000_0000, 0);
    add_item(CMD_INSERT, 32'sh0, 0);
    add_item(CMD_INSERT, 32'sh0, 0);
    add_item(CMD_APPEND, 32'sh8000_0000, 0);
    add_item(CMD_INSERT, 32'sh0001_0000, 0);
    add_item(CMD_INSERT, 32'shFFFF_FFFF, 0);
    add_item(CMD_INSERT, 32'sh7FFF_FFFF, 0);
    add_item(CMD_DUMP, $urandom, 0);
    add_item(CMD_UNUSED, 32'sh0, 0);
    add_item(CMD_INSERT, 32'sh0000_8000, 0);
    add_item(CMD_APPEND, 32'sh1234_5678, 0);
    add_item(CMD_DUMP, 32'shFFFF_FFFF, 0);

    // Random part: the store fills early, after which stores overflow and
    // dumps stream the full store. Idling changes by phase.
    while (stored_items < RANDOM_ITEMS) begin
      if (stored_items < RANDOM_ITEMS / 4) idle_pct = 0;
      else if (stored_items < RANDOM_ITEMS / 2) idle_pct = 86;
      else if (stored_items < 3 * RANDOM_ITEMS / 4) idle_pct = 38;
      else idle_pct = 0;
      pick = $urandom_range(99);
      if (pick < 5) begin
        add_item(CMD_UNUSED, $urandom, idle_pct);
      end else begin
        if (pick < 40) add_item(CMD_INSERT, pick_value(), idle_pct);
        else if (pick < 65) add_item(CMD_APPEND, pick_value(), idle_pct);
        else add_item(CMD_DUMP, $urandom, idle_pct);
        stored_items++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to be taken, then for every result.
    do @(negedge clk); while (pending_items.size() != 0 || start);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS sorted_list_insert");
    end else begin
      $display("FAIL sorted_list_insert");
    end
    $finish;
  end

endmodule
